// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define CMH_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define CMH_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/cmh_pkg.sv =====
// ----------------------------------------------------------------------------
// cmh_pkg
// Shared types and constants of the color matrix and histogram core.
// ----------------------------------------------------------------------------
package cmh_pkg;

  localparam int PIX_W     = 16;
  localparam int COEF_W    = 16;
  localparam int PROD_W    = 33;
  localparam int SUM_W     = 35;
  localparam int CNT_W     = 32;
  localparam int BIN_SHIFT = 3;
  localparam int RAW_BIN_W = PIX_W - BIN_SHIFT;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int HCH_W     = 2;

  localparam logic [PIX_W-1:0] PIX_MAX = 16'hffff;
  localparam logic [CNT_W-1:0] CNT_MAX = 32'hffff_ffff;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEF_R0_C01   = 3'd0,
    CFG_COEF_R0_C23   = 3'd1,
    CFG_COEF_R1_C01   = 3'd2,
    CFG_COEF_R1_C23   = 3'd3,
    CFG_COEF_R2_C01   = 3'd4,
    CFG_COEF_R2_C23   = 3'd5,
    CFG_BYPASS        = 3'd6,
    CFG_CHANNEL_COUNT = 3'd7
  } cfg_idx_t;

  // One request as it travels down the front of the pipeline
  typedef struct packed {
    logic                      req;
    logic [3:0][PIX_W-1:0]     px;
    logic [HCH_W-1:0]          hch;
    logic [RAW_BIN_W-1:0]      hbin;
    logic                      clr;
  } item_t;

  // What one histogram lane does with the item in its update stage
  typedef struct packed {
    logic active;
    logic clear;
  } lane_cmd_t;

endpackage

// ===== design/cmh_ram.sv =====
// ----------------------------------------------------------------------------
// cmh_ram
// Generic single-write, single-read RAM with registered, enabled read.
// ----------------------------------------------------------------------------
module cmh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/cmh_row.sv =====
// ----------------------------------------------------------------------------
// cmh_row
// One matrix row: four products in one stage, sum and clip in the next.
// ----------------------------------------------------------------------------
module cmh_row #(
  parameter int COEF_FRAC_BITS = 12
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic [3:0][cmh_pkg::PIX_W-1:0] px,
  input  logic [3:0][cmh_pkg::COEF_W-1:0] coef,
  output logic [cmh_pkg::PIX_W-1:0]      res
);
  import cmh_pkg::*;

  logic signed [PROD_W-1:0] prod_r [4];
  logic signed [PROD_W-1:0] prod_nxt [4];
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  shifted;
  logic [PIX_W-1:0]         res_r;
  logic [PIX_W-1:0]         res_nxt;

  // Signed coefficient times unsigned pixel
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      prod_nxt[i] = PROD_W'($signed(coef[i]) * $signed({1'b0, px[i]}));
    end
  end

  // Sum, truncate toward zero, clip to the pixel range
  always_comb begin
    sum = SUM_W'(prod_r[0]) + SUM_W'(prod_r[1]) + SUM_W'(prod_r[2]) + SUM_W'(prod_r[3]);
    shifted = sum >>> COEF_FRAC_BITS;
    if (sum <= 0) begin
      res_nxt = '0;
    end else if (shifted > SUM_W'(PIX_MAX)) begin
      res_nxt = PIX_MAX;
    end else begin
      res_nxt = shifted[PIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
      res_r  <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

// ===== design/cmh_lane.sv =====
// ----------------------------------------------------------------------------
// cmh_lane
// One channel's histogram: bin store with read-modify-write and forwarding.
// ----------------------------------------------------------------------------
module cmh_lane #(
  parameter int HIST_BINS = 8192
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         clr_busy,
  input  logic [$clog2(HIST_BINS)-1:0] clr_addr,
  input  logic [$clog2(HIST_BINS)-1:0] addr,
  input  cmh_pkg::lane_cmd_t           cmd,
  output logic [cmh_pkg::CNT_W-1:0]    count
);
  import cmh_pkg::*;

  localparam int BIN_W = $clog2(HIST_BINS);

  lane_cmd_t        cmd_r;
  logic [BIN_W-1:0] addr_r;
  logic             fwd_v_r;
  logic [BIN_W-1:0] fwd_addr_r;
  logic [CNT_W-1:0] fwd_data_r;
  logic [CNT_W-1:0] rdata;
  logic [CNT_W-1:0] cur;
  logic [CNT_W-1:0] upd;
  logic             upd_we;
  logic             ram_we;
  logic [BIN_W-1:0] ram_waddr;
  logic [CNT_W-1:0] ram_wdata;

  // Take the value of the write issued alongside this item's read
  assign cur    = (fwd_v_r && fwd_addr_r == addr_r) ? fwd_data_r : rdata;
  assign upd    = cmd_r.clear ? '0 : ((cur == CNT_MAX) ? cur : cur + 1'b1);
  assign upd_we = en && cmd_r.active;
  assign count  = cur;

  // Clearing pass has the write port after reset
  always_comb begin
    if (clr_busy) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = upd_we;
      ram_waddr = addr_r;
      ram_wdata = upd;
    end
  end

  cmh_ram #(
    .WIDTH (CNT_W),
    .DEPTH (HIST_BINS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (en),
    .raddr (addr),
    .rdata (rdata)
  );

  // Advance the update stage and the forwarding record
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r   <= '0;
      fwd_v_r <= 1'b0;
    end else if (en) begin
      cmd_r   <= cmd;
      fwd_v_r <= upd_we;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      addr_r     <= addr;
      fwd_addr_r <= addr_r;
      fwd_data_r <= upd;
    end
  end

endmodule

// ===== design/color_matrix_with_histogram_core.sv =====
// ----------------------------------------------------------------------------
// color_matrix_with_histogram_core
// 3x4 color matrix on 16-bit pixels with per-channel saturating histograms.
// ----------------------------------------------------------------------------
// Accepts one transaction per clock while in_tready is high (no output stall and
// no clearing pass) and returns one result per transaction, in order. Three row
// units each hold four multipliers (product stage, then sum and clip stage); one
// histogram lane per channel does a read-modify-write on its own single-port-write
// RAM, with the preceding item's write forwarded so that back-to-back hits on one
// bin count correctly. After reset a clearing pass zeroes the stores, during which
// in_tready stays low; configuration writes are taken meanwhile.
// ----------------------------------------------------------------------------
module color_matrix_with_histogram_core #(
  parameter int HIST_BINS      = 8192,
  parameter int NUM_CHANNELS   = 4,
  parameter int COEF_FRAC_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // ch0[15:0] ch1[31:16] ch2[47:32] ch3[63:48] hist_channel[65:64]
  // hist_bin[78:66] clear_after_read[79]
  input  logic [79:0]                   in_tdata,
  // req_type[0]
  input  logic                          in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // ch0[15:0] ch1[31:16] ch2[47:32] ch3[63:48] bin_count[95:64]
  output logic [95:0]                   out_tdata,
  // resp_type[0]
  output logic                          out_tuser,
  input  logic                          cfg_we,
  input  logic [cmh_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [cmh_pkg::CFG_W-1:0]     cfg_wdata
);
  import cmh_pkg::*;

  localparam int BIN_W = $clog2(HIST_BINS);

  logic [CFG_W-1:0] coef_r [6];
  logic             bypass_r;
  logic [2:0]       chan_cnt_r;

  logic             en;
  logic             clr_busy_r;
  logic [BIN_W-1:0] clr_cnt_r;

  logic             v1_r, v2_r, v3_r, v4_r;
  item_t            it1_r, it2_r, it3_r;
  logic [2:0][PIX_W-1:0] row_res;
  logic [3:0][PIX_W-1:0] res3;
  logic [3:0][PIX_W-1:0] res4_r;
  logic             req4_r;
  logic             rd_ok3, rd_ok4_r;
  logic [HCH_W-1:0] hch4_r;
  logic [2:0]       cc_eff;
  logic [BIN_W-1:0] rd_addr;

  logic [BIN_W-1:0] lane_addr [NUM_CHANNELS];
  lane_cmd_t        lane_cmd  [NUM_CHANNELS];
  logic [CNT_W-1:0] lane_cnt  [NUM_CHANNELS];

  logic             out_valid_r;
  logic             out_user_r;
  logic [95:0]      out_data_r;
  logic [95:0]      out_data_nxt;
  logic [CNT_W-1:0] bin_cnt;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r[0]  <= 32'h0000_1000;
      coef_r[1]  <= '0;
      coef_r[2]  <= 32'h1000_0000;
      coef_r[3]  <= '0;
      coef_r[4]  <= '0;
      coef_r[5]  <= 32'h0000_1000;
      bypass_r   <= 1'b0;
      chan_cnt_r <= 3'd3;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        CFG_COEF_R0_C01:   coef_r[0]  <= cfg_wdata;
        CFG_COEF_R0_C23:   coef_r[1]  <= cfg_wdata;
        CFG_COEF_R1_C01:   coef_r[2]  <= cfg_wdata;
        CFG_COEF_R1_C23:   coef_r[3]  <= cfg_wdata;
        CFG_COEF_R2_C01:   coef_r[4]  <= cfg_wdata;
        CFG_COEF_R2_C23:   coef_r[5]  <= cfg_wdata;
        CFG_BYPASS:        bypass_r   <= cfg_wdata[0];
        CFG_CHANNEL_COUNT: chan_cnt_r <= cfg_wdata[2:0];
        default:           bypass_r   <= bypass_r;
      endcase
    end
  end

  // Clearing pass over all bins after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clr_busy_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == BIN_W'(HIST_BINS - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  // Whole pipeline advances while the output register can take a result
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en && !clr_busy_r;

  // Valid bits of the front stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid && in_tready;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // Payload of the front stages
  always_ff @(posedge clk) begin
    if (en) begin
      it1_r.req  <= in_tuser;
      it1_r.px   <= in_tdata[63:0];
      it1_r.hch  <= in_tdata[65:64];
      it1_r.hbin <= in_tdata[78:66];
      it1_r.clr  <= in_tdata[79];
      it2_r      <= it1_r;
      it3_r      <= it2_r;
    end
  end

  // Row units, one per converted channel
  for (genvar r = 0; r < 3; r++) begin : g_row
    cmh_row #(
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_row (
      .clk  (clk),
      .en   (en),
      .px   (it1_r.px),
      .coef ({coef_r[2*r+1][31:16], coef_r[2*r+1][15:0],
              coef_r[2*r][31:16],   coef_r[2*r][15:0]}),
      .res  (row_res[r])
    );
  end

  // Select converted or passed-through pixel; bound the counted channels
  always_comb begin
    if (bypass_r || chan_cnt_r == 3'd1) begin
      res3 = it3_r.px;
    end else begin
      res3 = {it3_r.px[3], row_res[2], row_res[1], row_res[0]};
    end
    cc_eff  = (32'(chan_cnt_r) > NUM_CHANNELS) ? 3'(NUM_CHANNELS) : chan_cnt_r;
    rd_ok3  = (32'(it3_r.hch) < NUM_CHANNELS) && (32'(it3_r.hbin) < HIST_BINS);
    rd_addr = BIN_W'(it3_r.hbin);
  end

  // Histogram lanes
  for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_lane
    logic [RAW_BIN_W-1:0] raw_bin;

    always_comb begin
      raw_bin = res3[c][PIX_W-1:BIN_SHIFT];
      if (it3_r.req == REQ_READ) begin
        lane_addr[c]       = rd_addr;
        lane_cmd[c].active = v3_r && rd_ok3 && it3_r.clr && (32'(it3_r.hch) == c);
        lane_cmd[c].clear  = 1'b1;
      end else begin
        lane_addr[c]       = (32'(raw_bin) >= HIST_BINS) ? BIN_W'(HIST_BINS - 1)
                                                         : BIN_W'(raw_bin);
        lane_cmd[c].active = v3_r && (c < 32'(cc_eff));
        lane_cmd[c].clear  = 1'b0;
      end
    end

    cmh_lane #(
      .HIST_BINS (HIST_BINS)
    ) u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .clr_busy (clr_busy_r),
      .clr_addr (clr_cnt_r),
      .addr     (lane_addr[c]),
      .cmd      (lane_cmd[c]),
      .count    (lane_cnt[c])
    );
  end

  // Update stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      req4_r   <= it3_r.req;
      res4_r   <= res3;
      rd_ok4_r <= rd_ok3;
      hch4_r   <= it3_r.hch;
    end
  end

  // Merge the lanes into one result
  always_comb begin
    bin_cnt = '0;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      if (rd_ok4_r && 32'(hch4_r) == c) begin
        bin_cnt = lane_cnt[c];
      end
    end
    if (req4_r == REQ_READ) begin
      out_data_nxt = {bin_cnt, 64'd0};
    end else begin
      out_data_nxt = {32'd0, res4_r};
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_user_r <= req4_r;
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_user_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== design/cmh_checker.sv =====
// ----------------------------------------------------------------------------
// cmh_checker
// Port-level checks of the color matrix and histogram core.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cmh_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [95:0] out_tdata,
  input logic        out_tuser
);

  // Hold a result until it is taken
  `CMH_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid, "result dropped")
  // A pixel carries no bin count
  `CMH_ASSERT(a_pix_cnt, clk, rst_n, out_tvalid && !out_tuser |-> out_tdata[95:64] == 32'd0, "pixel with count")
  // A bin read carries no pixel
  `CMH_ASSERT(a_rd_pix, clk, rst_n, out_tvalid && out_tuser |-> out_tdata[63:0] == 64'd0, "bin read with pixel")
  // Reset empties the output and closes the input
  `CMH_ASSERT_ALWAYS(a_rst, clk, !rst_n |=> !out_tvalid && !in_tready, "output valid after reset")

endmodule

bind color_matrix_with_histogram_core cmh_checker u_cmh_checker (.*);
